[hw/rtl/port_binding_table_core_defines.svh]
// ----------------------------------------------------------------------------
// Port binding table assertion macros
// Shared concurrent assertion forms for the port binding table checkers.
// ----------------------------------------------------------------------------
`ifndef PORT_BINDING_TABLE_CORE_DEFINES_SVH
`define PORT_BINDING_TABLE_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is held
`define PBT_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("port binding table: assertion failed");

// Clocked assertion that also runs through reset
`define PBT_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("port binding table: reset assertion failed");

`endif

[hw/rtl/pbt_pkg.sv]
// ----------------------------------------------------------------------------
// Port binding table package
// Sizes, command codes and constants shared by the core and its checker.
// ----------------------------------------------------------------------------
package pbt_pkg;

  // Table depth and derived index width
  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed field widths
  localparam int CMD_W      = 2;
  localparam int PORT_W     = 16;
  localparam int IDX_W      = 4;
  localparam int OUT_SLOT_W = 3;
  localparam int TOTAL_W    = 32;

  typedef logic [CMD_W-1:0] cmd_t;

  // Command codes
  localparam cmd_t CMD_BIND   = 2'd0;
  localparam cmd_t CMD_AUTO   = 2'd1;
  localparam cmd_t CMD_UNBIND = 2'd2;
  localparam cmd_t CMD_INIT   = 2'd3;

  // Ephemeral port range
  localparam logic [PORT_W-1:0] EPHEMERAL_FIRST = 16'd49152;
  localparam logic [PORT_W-1:0] PORT_MAX        = 16'd65535;

endpackage

[hw/rtl/port_binding_table_core.sv]
// ----------------------------------------------------------------------------
// Port binding table core
// Local port binding table with lowest-free slot allocation and an upward
// ephemeral port search, built around one shared port comparator.
// ----------------------------------------------------------------------------
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+------------------------
// request  | in_command, in_port, in_slot_index      | start high, busy low
// result   | out_ok, out_slot, out_bound_port,       | out_valid, one cycle
//          | out_bind_total                          |
//
// Bind: the comparator visits one slot a cycle; the result strobes once the
// sweep over all slots is done. Auto-bind repeats that sweep once per port
// tried, at most SLOTS sweeps, since a free slot is required to start.
// Unbind, init and requests rejected up front strobe on the next cycle.
// busy is high during a sweep only. Synchronous reset empties the table and
// clears ready; init must be issued before binds succeed.
// The result cannot be stalled: it is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module port_binding_table_core
  import pbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [PORT_W-1:0]     in_port,
  input  logic [IDX_W-1:0]      in_slot_index,
  output logic                  busy,
  output logic                  out_valid,
  output logic                  out_ok,
  output logic [OUT_SLOT_W-1:0] out_slot,
  output logic [PORT_W-1:0]     out_bound_port,
  output logic [TOTAL_W-1:0]    out_bind_total
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Sequencer and scan state
  logic                  state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [PORT_W-1:0]     cur_port_r, cur_port_nxt;
  logic [SLOT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                  taken_r, taken_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]     free_idx_r, free_idx_nxt;

  // Table state
  logic [SLOTS-1:0]      slot_in_use_r, slot_in_use_nxt;
  logic [PORT_W-1:0]     slot_port_r [SLOTS];
  logic                  ready_r, ready_nxt;
  logic [PORT_W-1:0]     next_eph_r, next_eph_nxt;
  logic [TOTAL_W-1:0]    bind_count_r, bind_count_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [PORT_W-1:0]     out_bound_port_r, out_bound_port_nxt;
  logic [TOTAL_W-1:0]    out_bind_total_r, out_bind_total_nxt;

  // Shared comparator and scan bookkeeping
  logic                  hit;
  logic                  scan_last;
  logic                  taken_fin;
  logic                  free_found_fin;
  logic [SLOT_W-1:0]     free_idx_fin;
  logic                  port_we;
  logic                  idx_in_range;
  logic [SLOT_W-1:0]     idx_s;

  assign hit            = slot_in_use_r[scan_cnt_r] &&
                          (slot_port_r[scan_cnt_r] == cur_port_r);
  assign scan_last      = (scan_cnt_r == SLOT_W'(SLOTS - 1));
  assign taken_fin      = taken_r | hit;
  assign free_found_fin = free_found_r | !slot_in_use_r[scan_cnt_r];
  assign free_idx_fin   = free_found_r ? free_idx_r : scan_cnt_r;
  assign idx_in_range   = (32'(in_slot_index) < 32'(SLOTS));
  assign idx_s          = SLOT_W'(in_slot_index);

  // Next-state logic
  always_comb begin
    state_nxt          = state_r;
    cmd_nxt            = cmd_r;
    cur_port_nxt       = cur_port_r;
    scan_cnt_nxt       = scan_cnt_r;
    taken_nxt          = taken_r;
    free_found_nxt     = free_found_r;
    free_idx_nxt       = free_idx_r;
    slot_in_use_nxt    = slot_in_use_r;
    ready_nxt          = ready_r;
    next_eph_nxt       = next_eph_r;
    bind_count_nxt     = bind_count_r;
    out_valid_nxt      = 1'b0;
    out_ok_nxt         = out_ok_r;
    out_slot_nxt       = out_slot_r;
    out_bound_port_nxt = out_bound_port_r;
    out_bind_total_nxt = out_bind_total_r;
    port_we            = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt            = in_command;
          scan_cnt_nxt       = '0;
          taken_nxt          = 1'b0;
          free_found_nxt     = 1'b0;
          out_ok_nxt         = 1'b0;
          out_slot_nxt       = '0;
          out_bound_port_nxt = '0;
          out_bind_total_nxt = bind_count_r;
          unique case (in_command)
            CMD_BIND: begin
              if (!ready_r || (in_port == '0)) begin
                out_valid_nxt = 1'b1;
              end else begin
                cur_port_nxt = in_port;
                state_nxt    = ST_SCAN;
              end
            end
            CMD_AUTO: begin
              if (!ready_r || (next_eph_r == '0) || (&slot_in_use_r)) begin
                out_valid_nxt = 1'b1;
              end else begin
                cur_port_nxt = next_eph_r;
                state_nxt    = ST_SCAN;
              end
            end
            CMD_UNBIND: begin
              out_valid_nxt = 1'b1;
              if (idx_in_range && slot_in_use_r[idx_s]) begin
                slot_in_use_nxt[idx_s] = 1'b0;
                out_ok_nxt             = 1'b1;
              end
            end
            CMD_INIT: begin
              out_valid_nxt      = 1'b1;
              slot_in_use_nxt    = '0;
              bind_count_nxt     = '0;
              ready_nxt          = 1'b1;
              out_bind_total_nxt = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // One slot compared per cycle
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        taken_nxt    = taken_fin;
        if (!free_found_r && !slot_in_use_r[scan_cnt_r]) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = scan_cnt_r;
        end
        if (scan_last) begin
          scan_cnt_nxt   = '0;
          taken_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          priority if (!taken_fin && free_found_fin) begin
            // Port free and a slot open: commit
            slot_in_use_nxt[free_idx_fin] = 1'b1;
            port_we            = 1'b1;
            bind_count_nxt     = bind_count_r + 32'd1;
            out_valid_nxt      = 1'b1;
            out_ok_nxt         = 1'b1;
            out_slot_nxt       = OUT_SLOT_W'(free_idx_fin);
            out_bound_port_nxt = cur_port_r;
            out_bind_total_nxt = bind_count_r + 32'd1;
            state_nxt          = ST_IDLE;
            if (cmd_r == CMD_AUTO) begin
              next_eph_nxt = (cur_port_r == PORT_MAX) ? EPHEMERAL_FIRST
                                                      : cur_port_r + 16'd1;
            end
          end else if (taken_fin && (cmd_r == CMD_AUTO) &&
                       (cur_port_r != PORT_MAX)) begin
            // Port in use: try the next one
            cur_port_nxt = cur_port_r + 16'd1;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      slot_in_use_r <= '0;
      ready_r       <= 1'b0;
      next_eph_r    <= EPHEMERAL_FIRST;
      bind_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      slot_in_use_r <= slot_in_use_nxt;
      ready_r       <= ready_nxt;
      next_eph_r    <= next_eph_nxt;
      bind_count_r  <= bind_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r            <= cmd_nxt;
    cur_port_r       <= cur_port_nxt;
    scan_cnt_r       <= scan_cnt_nxt;
    taken_r          <= taken_nxt;
    free_found_r     <= free_found_nxt;
    free_idx_r       <= free_idx_nxt;
    out_ok_r         <= out_ok_nxt;
    out_slot_r       <= out_slot_nxt;
    out_bound_port_r <= out_bound_port_nxt;
    out_bind_total_r <= out_bind_total_nxt;
  end

  // Slot port store, written on commit
  always_ff @(posedge clk) begin
    if (port_we) begin
      slot_port_r[free_idx_fin] <= cur_port_r;
    end
  end

  assign busy           = (state_r == ST_SCAN);
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_slot       = out_slot_r;
  assign out_bound_port = out_bound_port_r;
  assign out_bind_total = out_bind_total_r;

endmodule

[hw/rtl/pbt_checker.sv]
// ----------------------------------------------------------------------------
// Port binding table checker
// Port-level checks on request/result sequencing of the binding table core.
// ----------------------------------------------------------------------------
`include "port_binding_table_core_defines.svh"

module pbt_checker
  import pbt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic                  out_ok,
  input logic [OUT_SLOT_W-1:0] out_slot,
  input logic [PORT_W-1:0]     out_bound_port
);

  // Reset leaves the core idle with no result
  `PBT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy && !out_valid)

  // A taken request either starts a sweep or answers at once
  `PBT_ASSERT(a_accept_reacts, clk, rst_n, start && !busy |=> busy || out_valid)

  // A sweep only ends by showing its result
  `PBT_ASSERT(a_sweep_ends_in_result, clk, rst_n, busy |=> busy || out_valid)

  // Results never strobe mid-sweep
  `PBT_ASSERT(a_result_when_idle, clk, rst_n, out_valid |-> !busy)

  // A failed request reports no slot and no port
  `PBT_ASSERT(a_fail_fields_zero, clk, rst_n, out_valid && !out_ok |-> out_slot == '0 && out_bound_port == '0)

endmodule

bind port_binding_table_core pbt_checker u_pbt_checker (.*);

[verif/port_binding_table_checker.sv]
// ----------------------------------------------------------------------------
// Port binding table checker
// Watches the request and result channels of the binding table, keeps its own
// copy of the slot table, ready flag, ephemeral pointer and bind total, and
// compares every result strobe field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module port_binding_table_checker
  import pbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [PORT_W-1:0]     in_port,
  input  logic [IDX_W-1:0]      in_slot_index,
  input  logic                  out_valid,
  input  logic                  out_ok,
  input  logic [OUT_SLOT_W-1:0] out_slot,
  input  logic [PORT_W-1:0]     out_bound_port,
  input  logic [TOTAL_W-1:0]    out_bind_total,
  output int                    mismatches,
  output int                    pending,
  output int                    results_seen,
  output int                    grants_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  ok;
    logic [OUT_SLOT_W-1:0] slot;
    logic [PORT_W-1:0]     port;
    logic [TOTAL_W-1:0]    total;
  } bind_outcome_t;

  // Shadow copy of the table
  logic                slot_taken  [SLOTS];
  logic [PORT_W-1:0]   slot_owner  [SLOTS];
  logic                table_ready;
  logic [PORT_W-1:0]   ephem_ptr;
  logic [TOTAL_W-1:0]  bind_cnt;
  bind_outcome_t       outcome_q [$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
    grants_seen  = 0;
  end

  task automatic note_failure(input string msg);
    $display("[%0t ns] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_taken[i] = 1'b0;
      slot_owner[i] = '0;
    end
  endtask

  function automatic bit port_in_use(input logic [PORT_W-1:0] p);
    for (int i = 0; i < SLOTS; i++)
      if (slot_taken[i] && slot_owner[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < SLOTS; i++)
      if (!slot_taken[i]) return i;
    return -1;
  endfunction

  // Takes the lowest free slot for p; -1 when the bind is refused
  function automatic int claim_slot(input logic [PORT_W-1:0] p);
    int s;
    if (!table_ready || p == '0 || port_in_use(p)) return -1;
    s = first_free_slot();
    if (s < 0) return -1;
    slot_taken[s] = 1'b1;
    slot_owner[s] = p;
    bind_cnt      = bind_cnt + 1;
    return s;
  endfunction

  // Works out the result of one request and queues it
  task automatic predict_request(input cmd_t cmd, input logic [PORT_W-1:0] port,
                                 input logic [IDX_W-1:0] idx);
    bind_outcome_t r;
    int            s;
    int            p;
    r = '0;
    case (cmd)
      CMD_BIND: begin
        s = claim_slot(port);
        if (s >= 0) begin
          r.ok   = 1'b1;
          r.slot = s[OUT_SLOT_W-1:0];
          r.port = port;
        end
      end
      CMD_AUTO: begin
        p = int'(ephem_ptr);
        // upward search, no wrap past the top port
        if (table_ready && p != 0 && first_free_slot() >= 0) begin
          while (1) begin
            s = claim_slot(p[PORT_W-1:0]);
            if (s >= 0) begin
              r.ok      = 1'b1;
              r.slot    = s[OUT_SLOT_W-1:0];
              r.port    = p[PORT_W-1:0];
              ephem_ptr = (p == int'(PORT_MAX)) ? EPHEMERAL_FIRST : p[PORT_W-1:0] + 1'b1;
              break;
            end
            if (p >= int'(PORT_MAX)) break;
            p++;
          end
        end
      end
      CMD_UNBIND: begin
        if (int'(idx) < SLOTS && slot_taken[idx]) begin
          slot_taken[idx] = 1'b0;
          slot_owner[idx] = '0;
          r.ok            = 1'b1;
        end
      end
      default: begin
        clear_table();
        bind_cnt    = '0;
        table_ready = 1'b1;
      end
    endcase
    r.total = bind_cnt;
    outcome_q.push_back(r);
  endtask

  // Result check first (it is always for an older request), then new request
  always @(posedge clk) begin
    bind_outcome_t e;
    if (!rst_n) begin
      clear_table();
      table_ready = 1'b0;
      ephem_ptr   = EPHEMERAL_FIRST;
      bind_cnt    = '0;
      outcome_q.delete();
    end else begin
      if (out_valid) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          note_failure("result strobe with no request outstanding");
        end else begin
          e = outcome_q.pop_front();
          if (out_ok) grants_seen++;
          if (out_ok !== e.ok)
            note_failure($sformatf("ok expected %0d got %0d", e.ok, out_ok));
          if (out_slot !== e.slot)
            note_failure($sformatf("slot expected %0d got %0d", e.slot, out_slot));
          if (out_bound_port !== e.port)
            note_failure($sformatf("bound_port expected %0d got %0d",
                                   e.port, out_bound_port));
          if (out_bind_total !== e.total)
            note_failure($sformatf("bind_total expected %0d got %0d",
                                   e.total, out_bind_total));
        end
      end
      if (start && !busy) predict_request(cmd_t'(in_command), in_port, in_slot_index);
    end
    pending = outcome_q.size();
  end

endmodule

[verif/tb_port_binding_table_core.sv]
// ----------------------------------------------------------------------------
// Port binding table testbench
// Drives bind, auto-bind, unbind and init requests into the core: a not-ready
// check, a short walk of the ephemeral pointer, directed corner cases, then
// random traffic under changing sender gaps. The checker module predicts and
// compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_port_binding_table_core;
  import pbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic [CMD_W-1:0]      in_command;
  logic [PORT_W-1:0]     in_port;
  logic [IDX_W-1:0]      in_slot_index;
  logic                  busy;
  logic                  out_valid;
  logic                  out_ok;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic [PORT_W-1:0]     out_bound_port;
  logic [TOTAL_W-1:0]    out_bind_total;

  int mismatches;
  int pending;
  int results_seen;
  int grants_seen;

  int idle_pct;
  int cmd_sent [4];

  localparam int SWEEP_BINDS   = 16;
  localparam int RANDOM_PHASE  = 430;

  port_binding_table_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_command     (in_command),
    .in_port        (in_port),
    .in_slot_index  (in_slot_index),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_slot       (out_slot),
    .out_bound_port (out_bound_port),
    .out_bind_total (out_bind_total)
  );

  port_binding_table_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_port        (in_port),
    .in_slot_index  (in_slot_index),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_slot       (out_slot),
    .out_bound_port (out_bound_port),
    .out_bind_total (out_bind_total),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_seen   (results_seen),
    .grants_seen    (grants_seen)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop
  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Present one request and hold it until taken; then maybe go quiet a while
  task automatic send_request(input cmd_t cmd, input logic [PORT_W-1:0] port,
                              input logic [IDX_W-1:0] idx);
    start         <= 1'b1;
    in_command    <= cmd;
    in_port       <= port;
    in_slot_index <= idx;
    // busy only moves at the rising edge, so look at it mid-cycle
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    cmd_sent[cmd]++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Ports: a reused pool for collisions, the ephemeral range, and anything
  function automatic logic [PORT_W-1:0] pick_port();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) begin
      case ($urandom_range(11))
        0:       return 16'd0;
        1:       return 16'd1;
        2:       return 16'd7;
        3:       return 16'd80;
        4:       return 16'd443;
        5:       return 16'd1024;
        6:       return EPHEMERAL_FIRST;
        7:       return EPHEMERAL_FIRST + 16'd1;
        8:       return EPHEMERAL_FIRST + 16'd3;
        9:       return PORT_MAX - 16'd1;
        10:      return PORT_MAX;
        default: return 16'h8000;
      endcase
    end else if (sel < 70) begin
      return EPHEMERAL_FIRST + 16'($urandom_range(2047));
    end
    return 16'($urandom);
  endfunction

  task automatic random_request();
    int                sel;
    logic [IDX_W-1:0]  idx;
    sel = $urandom_range(99);
    idx = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(15, 8))
                                   : IDX_W'($urandom_range(SLOTS - 1));
    if (sel < 40)      send_request(CMD_BIND, pick_port(), idx);
    else if (sel < 62) send_request(CMD_AUTO, pick_port(), idx);
    else if (sel < 96) send_request(CMD_UNBIND, pick_port(), idx);
    else               send_request(CMD_INIT, pick_port(), idx);
  endtask

  // Stimulus
  initial begin
    start         <= 1'b0;
    in_command    <= CMD_BIND;
    in_port       <= '0;
    in_slot_index <= '0;
    rst_n         <= 1'b0;
    idle_pct      = 0;
    foreach (cmd_sent[i]) cmd_sent[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Not ready yet: bind, auto-bind and unbind refused, then init
    send_request(CMD_BIND, 16'd100, 4'd0);
    send_request(CMD_AUTO, 16'd0, 4'd0);
    send_request(CMD_UNBIND, 16'd0, 4'd0);
    send_request(CMD_INIT, 16'd0, 4'd0);

    // Walk the ephemeral pointer a few ports up
    for (int i = 0; i < SWEEP_BINDS; i++) begin
      send_request(CMD_AUTO, 16'd0, 4'd0);
      send_request(CMD_UNBIND, 16'd0, 4'd0);
    end

    // Ports just ahead of the pointer taken, so auto-bind skips over them
    send_request(CMD_BIND, EPHEMERAL_FIRST + 16'(SWEEP_BINDS), 4'd0);
    send_request(CMD_BIND, EPHEMERAL_FIRST + 16'(SWEEP_BINDS + 1), 4'd0);
    send_request(CMD_AUTO, 16'd0, 4'd0);
    send_request(CMD_AUTO, 16'd0, 4'd0);
    send_request(CMD_AUTO, 16'd0, 4'd0);
    send_request(CMD_UNBIND, 16'd0, 4'd1);
    send_request(CMD_AUTO, 16'd0, 4'd0);
    send_request(CMD_AUTO, 16'd0, 4'd0);
    // Port zero, duplicate, fill, full table
    send_request(CMD_BIND, 16'd0, 4'd0);
    send_request(CMD_BIND, EPHEMERAL_FIRST + 16'(SWEEP_BINDS), 4'd0);
    send_request(CMD_BIND, 16'd1, 4'd0);
    send_request(CMD_BIND, 16'd2, 4'd0);
    send_request(CMD_BIND, 16'd3, 4'd0);
    send_request(CMD_BIND, 16'd4, 4'd0);
    send_request(CMD_AUTO, 16'd0, 4'd0);
    // Unbind out of range twice, a used slot, then the same slot once free
    send_request(CMD_UNBIND, 16'd0, 4'd15);
    send_request(CMD_UNBIND, 16'd0, 4'd8);
    send_request(CMD_UNBIND, 16'd0, 4'd7);
    send_request(CMD_UNBIND, 16'd0, 4'd7);
    send_request(CMD_BIND, 16'h8000, 4'd0);
    // Init on a busy table, then unbind on the cleared table
    send_request(CMD_INIT, PORT_MAX, 4'd15);
    send_request(CMD_UNBIND, 16'd0, 4'd0);
    wait_drain();

    // Random traffic under three gap settings
    idle_pct = 6;
    repeat (RANDOM_PHASE) random_request();
    wait_drain();
    idle_pct = 79;
    repeat (RANDOM_PHASE) random_request();
    wait_drain();
    idle_pct = 0;
    repeat (RANDOM_PHASE) random_request();
    wait_drain();

    // Idle margin after the last drain, before the summary
    repeat (100) @(posedge clk);

    $display("Covered %0d binds, %0d auto-binds, %0d unbinds, %0d inits",
             cmd_sent[CMD_BIND], cmd_sent[CMD_AUTO], cmd_sent[CMD_UNBIND],
             cmd_sent[CMD_INIT]);
    $display("%0d results checked, %0d granted, %0d mismatches",
             results_seen, grants_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
